FILE: sv/msp_pkg.sv
// Package for the MSP v1 frame parser: widths, protocol characters,
// parser phase codes and the structs passed between the submodules.
// No dependencies.
package msp_pkg;

  // Largest payload accepted in one frame
  localparam int unsigned MaxPayload = 64;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 7;
  localparam int unsigned PosW  = 6;
  // Two payload banks, selected by the frame queue slot
  localparam int unsigned AddrW = PosW + 1;
  localparam int unsigned BufDepth = 2 ** AddrW;

  // Protocol characters
  localparam logic [ByteW-1:0] ChPreamble = 8'h24;  // '$'
  localparam logic [ByteW-1:0] ChM        = 8'h4D;  // 'M'
  localparam logic [ByteW-1:0] ChToFc     = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] ChFromFc   = 8'h3E;  // '>'

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PhIdle     = 7'b0000001,
    PhWantM    = 7'b0000010,
    PhWantDir  = 7'b0000100,
    PhWantSize = 7'b0001000,
    PhWantCmd  = 7'b0010000,
    PhPayload  = 7'b0100000,
    PhChecksum = 7'b1000000
  } phase_e;

  // Completed frame header handed from parser to drain
  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [SizeW-1:0] size;
    logic [ByteW-1:0] rx_sum;
    logic [ByteW-1:0] calc_sum;
  } frame_desc_t;

  // Payload buffer write port
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } buf_wr_t;

  // Frame queue status
  typedef struct packed {
    logic full;
    logic empty;
    logic wr_slot;
    logic rd_slot;
  } queue_stat_t;

endpackage

FILE: sv/msp_if.sv
// Stream interfaces for the MSP v1 frame parser: received byte channel
// and frame result channel. Depends on msp_pkg.
interface msp_in_if;
  logic                      valid;
  logic                      ready;
  logic [msp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_out_if;
  logic                      valid;
  logic                      ready;
  logic [msp_pkg::ByteW-1:0] command_code;
  logic [msp_pkg::SizeW-1:0] payload_size;
  logic [msp_pkg::ByteW-1:0] payload_byte;
  logic [msp_pkg::PosW-1:0]  payload_position;
  logic [msp_pkg::ByteW-1:0] received_checksum;
  logic [msp_pkg::ByteW-1:0] computed_checksum;
  logic                      frame_valid;
  logic                      last_of_frame;

  modport source (output valid, output command_code, output payload_size,
                  output payload_byte, output payload_position,
                  output received_checksum, output computed_checksum,
                  output frame_valid, output last_of_frame, input ready);
  modport sink   (input valid, input command_code, input payload_size,
                  input payload_byte, input payload_position,
                  input received_checksum, input computed_checksum,
                  input frame_valid, input last_of_frame, output ready);
endinterface

FILE: sv/msp_front.sv
// Front end of the MSP v1 parser: header state machine, checksum
// accumulation, payload buffer writes and frame header push.
// Depends on msp_pkg.
module msp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [msp_pkg::ByteW-1:0]   in_byte_i,
  output logic                        in_ready_o,
  input  msp_pkg::queue_stat_t        q_stat_i,
  output logic                        push_o,
  output msp_pkg::frame_desc_t        push_desc_o,
  output msp_pkg::buf_wr_t            buf_wr_o
);

  msp_pkg::phase_e           phase_q, phase_d;
  logic [msp_pkg::SizeW-1:0] count_q, count_d;
  logic [msp_pkg::ByteW-1:0] sum_q, sum_d;
  logic [msp_pkg::SizeW-1:0] size_q, size_d;
  logic [msp_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic                      take;
  logic [msp_pkg::SizeW-1:0] count_inc;

  // A free queue slot also means the matching payload bank is free
  assign in_ready_o = !q_stat_i.full;
  assign take       = in_valid_i && in_ready_o;
  assign count_inc  = count_q + msp_pkg::SizeW'(1);

  // Parser next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    size_d  = size_q;
    cmd_d   = cmd_q;
    push_o  = 1'b0;
    if (take) begin
      unique case (phase_q)
        msp_pkg::PhIdle: begin
          if (in_byte_i == msp_pkg::ChPreamble) phase_d = msp_pkg::PhWantM;
        end
        msp_pkg::PhWantM: begin
          if (in_byte_i == msp_pkg::ChM) begin
            phase_d = msp_pkg::PhWantDir;
          end else if (in_byte_i != msp_pkg::ChPreamble) begin
            phase_d = msp_pkg::PhIdle;
          end
        end
        msp_pkg::PhWantDir: begin
          if (in_byte_i == msp_pkg::ChToFc || in_byte_i == msp_pkg::ChFromFc) begin
            phase_d = msp_pkg::PhWantSize;
          end else begin
            phase_d = msp_pkg::PhIdle;
          end
        end
        msp_pkg::PhWantSize: begin
          if (in_byte_i > msp_pkg::ByteW'(msp_pkg::MaxPayload)) begin
            phase_d = msp_pkg::PhIdle;
          end else begin
            size_d  = in_byte_i[msp_pkg::SizeW-1:0];
            sum_d   = in_byte_i;
            phase_d = msp_pkg::PhWantCmd;
          end
        end
        msp_pkg::PhWantCmd: begin
          cmd_d   = in_byte_i;
          sum_d   = sum_q ^ in_byte_i;
          count_d = '0;
          phase_d = (size_q == '0) ? msp_pkg::PhChecksum : msp_pkg::PhPayload;
        end
        msp_pkg::PhPayload: begin
          sum_d   = sum_q ^ in_byte_i;
          count_d = count_inc;
          if (count_inc >= size_q) phase_d = msp_pkg::PhChecksum;
        end
        msp_pkg::PhChecksum: begin
          push_o  = 1'b1;
          phase_d = msp_pkg::PhIdle;
        end
        default: phase_d = msp_pkg::PhIdle;
      endcase
    end
  end

  // Frame header and payload write
  always_comb begin
    push_desc_o.command  = cmd_q;
    push_desc_o.size     = size_q;
    push_desc_o.rx_sum   = in_byte_i;
    push_desc_o.calc_sum = sum_q;
    buf_wr_o.en          = take && (phase_q == msp_pkg::PhPayload);
    buf_wr_o.addr        = {q_stat_i.wr_slot, count_q[msp_pkg::PosW-1:0]};
    buf_wr_o.data        = in_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= msp_pkg::PhIdle;
      count_q <= '0;
      sum_q   <= '0;
      size_q  <= '0;
      cmd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      size_q  <= size_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

FILE: sv/msp_queue.sv
// Two-slot queue of completed frame headers between parser and drain.
// Slot index doubles as payload bank select. Depends on msp_pkg.
module msp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  msp_pkg::frame_desc_t push_desc_i,
  input  logic                 pop_i,
  output msp_pkg::frame_desc_t head_o,
  output msp_pkg::queue_stat_t stat_o
);

  msp_pkg::frame_desc_t slot_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q, count_d;

  assign stat_o.full    = (count_q == 2'd2);
  assign stat_o.empty   = (count_q == 2'd0);
  assign stat_o.wr_slot = wr_ptr_q;
  assign stat_o.rd_slot = rd_ptr_q;
  assign head_o         = slot_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    else if (pop_i && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
    end
  end

  // Header storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_desc_i;
  end

endmodule

FILE: sv/msp_back.sv
// MSP v1 parser drain side, depends on msp_pkg: payload buffer (two banks)
// and sequencer emitting one result word per payload byte, one if empty.
module msp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msp_pkg::buf_wr_t               buf_wr_i,
  input  msp_pkg::frame_desc_t           head_i,
  input  msp_pkg::queue_stat_t           q_stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [msp_pkg::ByteW-1:0]      command_code_o,
  output logic [msp_pkg::SizeW-1:0]      payload_size_o,
  output logic [msp_pkg::ByteW-1:0]      payload_byte_o,
  output logic [msp_pkg::PosW-1:0]       payload_position_o,
  output logic [msp_pkg::ByteW-1:0]      received_checksum_o,
  output logic [msp_pkg::ByteW-1:0]      computed_checksum_o,
  output logic                           frame_valid_o,
  output logic                           last_of_frame_o
);

  logic [msp_pkg::ByteW-1:0] mem_q [msp_pkg::BufDepth];
  logic [msp_pkg::ByteW-1:0] rd_data_q;
  logic [msp_pkg::PosW-1:0]  pos_q;
  logic                      out_valid_q;
  msp_pkg::frame_desc_t      desc_q;
  logic [msp_pkg::PosW-1:0]  pos_out_q;
  logic                      last_q;
  logic                      adv, emit, is_last;
  logic [msp_pkg::SizeW-1:0] pos_next;

  // Output register free or being taken
  assign adv      = !out_valid_q || out_ready_i;
  assign emit     = adv && !q_stat_i.empty;
  assign pos_next = {1'b0, pos_q} + msp_pkg::SizeW'(1);
  assign is_last  = (head_i.size == '0) || (pos_next == head_i.size);
  assign pop_o    = emit && is_last;

  // Payload buffer
  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) mem_q[buf_wr_i.addr] <= buf_wr_i.data;
    if (emit) rd_data_q <= mem_q[{q_stat_i.rd_slot, pos_q}];
  end

  // Position counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) out_valid_q <= !q_stat_i.empty;
      if (emit) pos_q <= is_last ? '0 : pos_next[msp_pkg::PosW-1:0];
    end
  end

  // Output word fields
  always_ff @(posedge clk_i) begin
    if (emit) begin
      desc_q    <= head_i;
      pos_out_q <= pos_q;
      last_q    <= is_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign command_code_o      = desc_q.command;
  assign payload_size_o      = desc_q.size;
  assign payload_byte_o      = (desc_q.size == '0) ? '0 : rd_data_q;
  assign payload_position_o  = pos_out_q;
  assign received_checksum_o = desc_q.rx_sum;
  assign computed_checksum_o = desc_q.calc_sum;
  assign frame_valid_o       = (desc_q.rx_sum == desc_q.calc_sum);
  assign last_of_frame_o     = last_q;

endmodule

FILE: sv/msp_v1_frame_parser.sv
// MSP v1 frame parser top level. After the checksum byte is accepted, the
// header is queued, then the first result word is registered; the frame then
// drains one word per cycle while out ready is high. Input: one received
// byte per cycle while the two-slot frame queue has room, overlapping drain.
// Reset: asynchronous active low, parser idle and queue empty.
// Depends on msp_pkg, msp_if, msp_front, msp_queue, msp_back.
module msp_v1_frame_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  msp_in_if.sink    in_i,
  msp_out_if.source out_o
);

  msp_pkg::queue_stat_t q_stat;
  msp_pkg::frame_desc_t push_desc, head;
  msp_pkg::buf_wr_t     buf_wr;
  logic                 push, pop;

  msp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.rx_byte),
    .in_ready_o  (in_i.ready),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_desc_o (push_desc),
    .buf_wr_o    (buf_wr)
  );

  msp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  msp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .buf_wr_i            (buf_wr),
    .head_i              (head),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .command_code_o      (out_o.command_code),
    .payload_size_o      (out_o.payload_size),
    .payload_byte_o      (out_o.payload_byte),
    .payload_position_o  (out_o.payload_position),
    .received_checksum_o (out_o.received_checksum),
    .computed_checksum_o (out_o.computed_checksum),
    .frame_valid_o       (out_o.frame_valid),
    .last_of_frame_o     (out_o.last_of_frame)
  );

  // An empty frame is always a single, final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.payload_size == '0) |-> out_o.last_of_frame)
    else $error("empty frame word not marked last");

  // Position stays inside the payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.payload_size != '0) |->
      ({1'b0, out_o.payload_position} < out_o.payload_size))
    else $error("payload position beyond frame size");

  // A new frame run starts at position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_of_frame |=>
      (!out_o.valid || out_o.payload_position == '0))
    else $error("frame run did not restart at position zero");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("frame queue overflow");

endmodule
